// File: rtl/cpg_pkg.sv
package cpg_pkg;

    localparam int CORDIC_STEPS = 22;
    localparam int XW           = 33;
    localparam int ZW           = 26;
    localparam int QW           = 17;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int SCALE        = 500;

    localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);

    localparam logic [22:0] ATAN_TURNS24 [CORDIC_STEPS] = '{
        23'd2097152, 23'd1238021, 23'd654136, 23'd332050, 23'd166669, 23'd83416,
        23'd41718,   23'd20860,   23'd10430,  23'd5215,   23'd2608,   23'd1304,
        23'd652,     23'd326,     23'd163,    23'd81,     23'd41,     23'd20,
        23'd10,      23'd5,       23'd3,      23'd1
    };

    typedef logic signed [XW-1:0] t_cx;
    typedef logic signed [ZW-1:0] t_cz;
    typedef logic signed [QW-1:0] t_q15;

    typedef struct packed {
        logic [1:0]       quad;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_tag;

    function automatic t_q15 to_q15(input t_cx v);
        logic signed [XW:0] t;
        t_q15               r;
        t = ($signed({v[XW-1], v}) + (XW+1)'(16384)) >>> 15;
        if (t > (XW+1)'(32768)) begin
            r = QW'(32768);
        end else if (t < -(XW+1)'(32768)) begin
            r = -QW'(32768);
        end else begin
            r = QW'(t);
        end
        return r;
    endfunction

endpackage

// File: rtl/circle_point_generator_unit.sv
// Path: a taken request passes the bit-serial step divider and its handoff, then 22 CORDIC
// cells, then 3 registered stages after.
// Throughput: one point per cycle once issuing starts, while the output is not stalled; a
// request of n points holds the input stalled until its last point has left the output.
// Reset: synchronous active-low clears all control state and valid bits; block is idle after.
module circle_point_generator_unit #(
    parameter int MAX_POINTS = 64,
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_diameter,
    input  logic [6:0]  i_point_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [24:0] o_x_coord,
    output logic signed [24:0] o_y_coord,
    output logic [5:0]  o_point_index,
    output logic        o_last_point
);

    localparam int AB    = ANGLE_BITS;
    localparam int NUM_W = AB + 1;
    localparam int NS    = cpg_pkg::CORDIC_STEPS;
    localparam int CW    = cpg_pkg::CNT_W;
    localparam int IW    = cpg_pkg::IDX_W;
    localparam int RW    = 24;
    localparam int PW    = RW + cpg_pkg::QW + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_GEN   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_left, n_left;
    logic [IW-1:0] r_idx, n_idx;
    logic [AB-1:0] r_acc, n_acc, r_step;
    logic [RW-1:0] r_r500;

    logic          en, accept, div_start, div_done;
    logic [CW-1:0] n_sat;
    logic [NUM_W-1:0] div_num, div_quo;

    logic          c_valid [NS+1];
    cpg_pkg::t_cx  c_x     [NS+1];
    cpg_pkg::t_cx  c_y     [NS+1];
    cpg_pkg::t_cz  c_z     [NS+1];
    cpg_pkg::t_tag c_tag   [NS+1];

    logic          r_q_valid, r_m_valid, r_out_valid;
    cpg_pkg::t_q15 r_q_c, r_q_s, q_c, q_s, f_c, f_s;
    cpg_pkg::t_tag r_q_tag, r_m_tag, r_out_tag;
    logic signed [PW-1:0] r_m_x, r_m_y;
    logic signed [24:0]   r_out_x, r_out_y;

    function automatic logic signed [24:0] trunc_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p[PW-1] ? (p + PW'(32767)) >>> 15 : p >>> 15;
        return t[24:0];
    endfunction

    assign en         = !(r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign n_sat      = (32'(i_point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : i_point_count;
    assign div_num    = (NUM_W'(1) << AB) + NUM_W'(n_sat >> 1);
    assign div_start  = accept && (n_sat != '0);

    cpg_div #(
        .NUM_W(NUM_W),
        .DEN_W(CW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (n_sat),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_idx   = r_idx;
        n_acc   = r_acc;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_left = n_sat;
                    if (n_sat != '0) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_idx = '0;
                n_acc = '0;
                if (div_done) begin
                    n_state = S_GEN;
                end
            end
            S_GEN: begin
                if (en) begin
                    n_left = r_left - 1'b1;
                    n_idx  = r_idx + 1'b1;
                    n_acc  = r_acc + r_step;
                    if (r_left == CW'(1)) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (o_out_valid && !i_out_stall && o_last_point) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            if (div_done) begin
                r_step <= div_quo[AB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r500 <= RW'(i_diameter[15:1]) * RW'(cpg_pkg::SCALE);
        end
    end

    assign c_valid[0]     = r_state == S_GEN;
    assign c_x[0]         = cpg_pkg::CORDIC_X0;
    assign c_y[0]         = '0;
    assign c_z[0]         = cpg_pkg::ZW'(r_acc[AB-3:0]) << (24 - AB);
    assign c_tag[0].quad  = r_acc[AB-1:AB-2];
    assign c_tag[0].index = r_idx;
    assign c_tag[0].last  = r_left == CW'(1);

    for (genvar g = 0; g < NS; g++) begin : g_cell
        cpg_cell #(
            .STAGE(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(c_valid[g]),
            .i_x    (c_x[g]),
            .i_y    (c_y[g]),
            .i_z    (c_z[g]),
            .i_tag  (c_tag[g]),
            .o_valid(c_valid[g+1]),
            .o_x    (c_x[g+1]),
            .o_y    (c_y[g+1]),
            .o_z    (c_z[g+1]),
            .o_tag  (c_tag[g+1])
        );
    end

    always_comb begin
        q_c = cpg_pkg::to_q15(c_x[NS]);
        q_s = cpg_pkg::to_q15(c_y[NS]);
        case (c_tag[NS].quad)
            2'd0: begin
                f_c = q_c;
                f_s = q_s;
            end
            2'd1: begin
                f_c = -q_s;
                f_s = q_c;
            end
            2'd2: begin
                f_c = -q_c;
                f_s = -q_s;
            end
            default: begin
                f_c = q_s;
                f_s = -q_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_q_valid   <= c_valid[NS];
            r_m_valid   <= r_q_valid;
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_c     <= f_c;
            r_q_s     <= f_s;
            r_q_tag   <= c_tag[NS];
            r_m_x     <= $signed({1'b0, r_r500}) * r_q_c;
            r_m_y     <= $signed({1'b0, r_r500}) * r_q_s;
            r_m_tag   <= r_q_tag;
            r_out_x   <= trunc_scale(r_m_x);
            r_out_y   <= trunc_scale(r_m_y);
            r_out_tag <= r_m_tag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_x_coord     = r_out_x;
    assign o_y_coord     = r_out_y;
    assign o_point_index = r_out_tag.index;
    assign o_last_point  = r_out_tag.last;

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_point |-> r_state == S_DRAIN)
        else $error("last point outside drain");

    a_gen_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GEN |-> r_left != '0)
        else $error("issuing with no points left");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !o_out_valid && !r_m_valid && !r_q_valid)
        else $error("result pending while idle");

    a_div_to_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

endmodule

// File: rtl/cpg_cell.sv
module cpg_cell #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cpg_pkg::t_cx     i_x,
    input  cpg_pkg::t_cx     i_y,
    input  cpg_pkg::t_cz     i_z,
    input  cpg_pkg::t_tag    i_tag,
    output logic             o_valid,
    output cpg_pkg::t_cx     o_x,
    output cpg_pkg::t_cx     o_y,
    output cpg_pkg::t_cz     o_z,
    output cpg_pkg::t_tag    o_tag
);

    localparam cpg_pkg::t_cz ATAN = cpg_pkg::ZW'(cpg_pkg::ATAN_TURNS24[STAGE]);

    logic         r_valid;
    cpg_pkg::t_cx r_x, r_y;
    cpg_pkg::t_cz r_z;
    cpg_pkg::t_tag r_tag;
    cpg_pkg::t_cx n_x, n_y;
    cpg_pkg::t_cz n_z;
    cpg_pkg::t_cx dx, dy;

    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_z[cpg_pkg::ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

// File: rtl/cpg_div.sv
module cpg_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num, r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
        n_rem  = q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
